// ----- src/slaballoc_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants of the slab object allocator.
// Used by every module of the block but slaballoc_decode; depends on nothing.
package slaballoc_pkg;

    // Request modes.
    localparam logic MODE_ALLOCATE = 1'b0;
    localparam logic MODE_RELEASE  = 1'b1;

    // Configuration port: 32-bit registers, one word each.
    localparam int APB_ADDR_W = 3;
    // Word index of region_base (paddr bit 2).
    localparam logic REG_REGION_BASE = 1'b0;

    typedef enum logic [1:0] {
        STATUS_OK           = 2'd0,
        STATUS_OUT_OF_MEM   = 2'd1,
        STATUS_INVALID      = 2'd2,
        STATUS_ALREADY_FREE = 2'd3
    } status_t;

    typedef struct packed {
        logic        mode;
        logic [31:0] address;
    } in_item_t;

    typedef struct packed {
        status_t     status;
        logic [31:0] object_address;
    } out_item_t;

endpackage

// ----- src/slaballoc_apb.sv -----
`timescale 1ns / 1ps
// Configuration register file of the slab allocator, behind an APB-style port.
// Depends on slaballoc_pkg.
module slaballoc_apb (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [slaballoc_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [31:0]                          pwdata,
    output logic [31:0]                          prdata,
    output logic                                 pready,
    output logic [31:0]                          region_base
);

    logic [31:0] region_base_reg;
    logic        word_sel;

    assign word_sel    = paddr[2];
    assign pready      = 1'b1;
    assign region_base = region_base_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            region_base_reg <= '0;
        end else if (psel && penable && pwrite && pready
                     && word_sel == slaballoc_pkg::REG_REGION_BASE) begin
            region_base_reg <= pwdata;
        end
    end

    // Low address bits inside a word are ignored.
    always_comb begin
        if (word_sel == slaballoc_pkg::REG_REGION_BASE && paddr[1:0] == 2'b00) begin
            prdata = region_base_reg;
        end else if (word_sel == slaballoc_pkg::REG_REGION_BASE) begin
            prdata = region_base_reg;
        end else begin
            prdata = '0;
        end
    end

endmodule

// ----- src/slaballoc_decode.sv -----
`timescale 1ns / 1ps
// Release address decoder: range check and split into slab and object index.
// Uses nothing from the package; it is sized by the top level's parameters.
module slaballoc_decode #(
    parameter int NUM_SLABS        = 16,
    parameter int OBJECTS_PER_SLAB = 16,
    parameter int SLAB_BYTES       = 4096,
    parameter int OBJECT_BYTES     = 256
) (
    input  logic [31:0]                         address,
    input  logic [31:0]                         region_base,
    output logic                                invalid,
    output logic [$clog2(NUM_SLABS)-1:0]        slab,
    output logic [$clog2(OBJECTS_PER_SLAB)-1:0] obj
);

    localparam int SW = $clog2(NUM_SLABS);
    localparam int CW = $clog2(OBJECTS_PER_SLAB);
    localparam logic [31:0] REGION_BYTES = 32'(NUM_SLABS * SLAB_BYTES);
    localparam logic [31:0] SLAB_SPAN    = 32'(OBJECTS_PER_SLAB * OBJECT_BYTES);

    logic        below;
    logic        past_region;
    logic        past_slab;
    logic [31:0] offset;
    logic [31:0] in_slab_offset;

    assign below       = address < region_base;
    assign offset      = address - region_base;
    assign past_region = offset >= REGION_BYTES;

    // Slab index by comparing against every slab boundary at once.
    always_comb begin
        slab = '0;
        for (int k = 1; k < NUM_SLABS; k++) begin
            if (offset >= 32'(k * SLAB_BYTES)) begin
                slab = SW'(k);
            end
        end
    end

    assign in_slab_offset = offset - 32'(slab) * 32'(SLAB_BYTES);
    assign past_slab      = in_slab_offset >= SLAB_SPAN;

    always_comb begin
        obj = '0;
        for (int k = 1; k < OBJECTS_PER_SLAB; k++) begin
            if (in_slab_offset >= 32'(k * OBJECT_BYTES)) begin
                obj = CW'(k);
            end
        end
    end

    // Object 0 of every slab is reserved and can never be released.
    assign invalid = below || past_region || past_slab || (obj == '0);

endmodule

// ----- src/slaballoc_core.sv -----
`timescale 1ns / 1ps
// Slab state (free bitmaps, free counts, slab masks) with the allocate and
// release logic. Depends on slaballoc_pkg.
module slaballoc_core #(
    parameter int NUM_SLABS        = 16,
    parameter int OBJECTS_PER_SLAB = 16,
    parameter int SLAB_BYTES       = 4096,
    parameter int OBJECT_BYTES     = 256
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                step_en,
    input  slaballoc_pkg::in_item_t             item,
    input  logic [31:0]                         region_base,
    input  logic                                rel_invalid,
    input  logic [$clog2(NUM_SLABS)-1:0]        rel_slab,
    input  logic [$clog2(OBJECTS_PER_SLAB)-1:0] rel_obj,
    output slaballoc_pkg::out_item_t            result,
    output logic [NUM_SLABS-1:0]                empty_slabs,
    output logic [NUM_SLABS-1:0]                partial_slabs,
    output logic [NUM_SLABS-1:0]                full_slabs
);

    localparam int SW     = $clog2(NUM_SLABS);
    localparam int CW     = $clog2(OBJECTS_PER_SLAB);
    localparam int USABLE = OBJECTS_PER_SLAB - 1;

    logic [USABLE-1:0]    free_map_reg [NUM_SLABS];
    logic [CW-1:0]        free_count_reg [NUM_SLABS];
    logic [NUM_SLABS-1:0] empty_slabs_reg;
    logic [NUM_SLABS-1:0] partial_slabs_reg;
    logic [NUM_SLABS-1:0] full_slabs_reg;

    logic              alloc_found;
    logic [SW-1:0]     alloc_slab;
    logic [CW-1:0]     alloc_obj;
    logic [USABLE-1:0] alloc_onehot;
    logic [USABLE-1:0] rel_onehot;
    logic [SW-1:0]     sel_slab;
    logic [USABLE-1:0] sel_map;
    logic [CW-1:0]     sel_count;
    logic              do_update;
    logic [USABLE-1:0] map_next;
    logic [CW-1:0]     count_next;

    assign empty_slabs   = empty_slabs_reg;
    assign partial_slabs = partial_slabs_reg;
    assign full_slabs    = full_slabs_reg;

    // Lowest slab that still has a free object.
    always_comb begin
        alloc_found = 1'b0;
        alloc_slab  = '0;
        for (int k = NUM_SLABS - 1; k >= 0; k--) begin
            if (!full_slabs_reg[k]) begin
                alloc_found = 1'b1;
                alloc_slab  = SW'(k);
            end
        end
    end

    assign sel_slab  = (item.mode == slaballoc_pkg::MODE_RELEASE) ? rel_slab : alloc_slab;
    assign sel_map   = free_map_reg[sel_slab];
    assign sel_count = free_count_reg[sel_slab];

    // Lowest free object of the chosen slab; bit k stands for object k+1.
    always_comb begin
        alloc_obj = '0;
        for (int k = USABLE - 1; k >= 0; k--) begin
            if (sel_map[k]) begin
                alloc_obj = CW'(k + 1);
            end
        end
    end

    assign alloc_onehot = sel_map & (~sel_map + USABLE'(1));

    always_comb begin
        for (int k = 0; k < USABLE; k++) begin
            rel_onehot[k] = (rel_obj == CW'(k + 1));
        end
    end

    always_comb begin
        result.status         = slaballoc_pkg::STATUS_OK;
        result.object_address = '0;
        do_update             = 1'b0;
        map_next              = sel_map;
        count_next            = sel_count;
        if (item.mode == slaballoc_pkg::MODE_ALLOCATE) begin
            if (!alloc_found) begin
                result.status = slaballoc_pkg::STATUS_OUT_OF_MEM;
            end else begin
                do_update             = 1'b1;
                map_next              = sel_map & ~alloc_onehot;
                count_next            = sel_count - CW'(1);
                result.object_address = region_base
                                      + 32'(alloc_slab) * 32'(SLAB_BYTES)
                                      + 32'(alloc_obj) * 32'(OBJECT_BYTES);
            end
        end else if (rel_invalid) begin
            result.status = slaballoc_pkg::STATUS_INVALID;
        end else if ((sel_map & rel_onehot) != '0) begin
            result.status = slaballoc_pkg::STATUS_ALREADY_FREE;
        end else begin
            do_update  = 1'b1;
            map_next   = sel_map | rel_onehot;
            count_next = sel_count + CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < NUM_SLABS; k++) begin
                free_map_reg[k]   <= '1;
                free_count_reg[k] <= CW'(USABLE);
            end
            empty_slabs_reg   <= '1;
            partial_slabs_reg <= '0;
            full_slabs_reg    <= '0;
        end else if (step_en && do_update) begin
            free_map_reg[sel_slab]      <= map_next;
            free_count_reg[sel_slab]    <= count_next;
            full_slabs_reg[sel_slab]    <= (count_next == '0);
            empty_slabs_reg[sel_slab]   <= (count_next == CW'(USABLE));
            partial_slabs_reg[sel_slab] <= (count_next != '0)
                                        && (count_next != CW'(USABLE));
        end
    end

endmodule

// ----- src/slab_object_allocator_top.sv -----
`timescale 1ns / 1ps
// Top level of the slab object allocator: item registers and handshakes.
// Depends on slaballoc_pkg, slaballoc_apb, slaballoc_decode and slaballoc_core.

// The allocator hands out fixed-size objects from NUM_SLABS slabs of
// OBJECTS_PER_SLAB objects each; object 0 of every slab is reserved. An
// allocate item returns the address of the lowest free object in the lowest
// slab that is not full, or out_of_memory; a release item returns ok,
// invalid_address or already_free. Every accepted item gives exactly one
// result item. The block takes one item per clock cycle while the result
// side keeps draining: an item held in the input register is decoded and
// applied to the slab state in a single pass, and its result is registered
// as the item moves on. The rate rests on that single pass through the
// address decoder, the slab and object priority encoders and the bitmap
// update, which is why state written by one item is seen by the very next.
// When the result side stalls, the input register holds one more item and
// then ready drops. The region_base register sits at byte address 0 of the
// configuration port and is only to be written while no item is in flight;
// there is no clearing pass, the slab state is ready as soon as reset ends.
module slab_object_allocator_top #(
    parameter int NUM_SLABS        = 16,
    parameter int OBJECTS_PER_SLAB = 16,
    parameter int SLAB_BYTES       = 4096,
    parameter int OBJECT_BYTES     = 256
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // Request channel.
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  slaballoc_pkg::in_item_t              s_data,
    // Result channel.
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output slaballoc_pkg::out_item_t             m_data,
    // Configuration port.
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [slaballoc_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [31:0]                          pwdata,
    output logic [31:0]                          prdata,
    output logic                                 pready
);

    localparam int SW = $clog2(NUM_SLABS);
    localparam int CW = $clog2(OBJECTS_PER_SLAB);

    logic                     in_valid_reg;
    slaballoc_pkg::in_item_t  in_item_reg;
    logic                     out_valid_reg;
    slaballoc_pkg::out_item_t out_item_reg;

    logic                     advance;
    logic [31:0]              region_base;
    logic                     rel_invalid;
    logic [SW-1:0]            rel_slab;
    logic [CW-1:0]            rel_obj;
    slaballoc_pkg::out_item_t result;
    logic [NUM_SLABS-1:0]     empty_slabs;
    logic [NUM_SLABS-1:0]     partial_slabs;
    logic [NUM_SLABS-1:0]     full_slabs;

    // The held item moves on whenever the result register is empty or drains.
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign m_valid = out_valid_reg;
    assign m_data  = out_item_reg;

    slaballoc_apb u_apb (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .region_base (region_base)
    );

    slaballoc_decode #(
        .NUM_SLABS        (NUM_SLABS),
        .OBJECTS_PER_SLAB (OBJECTS_PER_SLAB),
        .SLAB_BYTES       (SLAB_BYTES),
        .OBJECT_BYTES     (OBJECT_BYTES)
    ) u_decode (
        .address     (in_item_reg.address),
        .region_base (region_base),
        .invalid     (rel_invalid),
        .slab        (rel_slab),
        .obj         (rel_obj)
    );

    slaballoc_core #(
        .NUM_SLABS        (NUM_SLABS),
        .OBJECTS_PER_SLAB (OBJECTS_PER_SLAB),
        .SLAB_BYTES       (SLAB_BYTES),
        .OBJECT_BYTES     (OBJECT_BYTES)
    ) u_core (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .step_en       (advance),
        .item          (in_item_reg),
        .region_base   (region_base),
        .rel_invalid   (rel_invalid),
        .rel_slab      (rel_slab),
        .rel_obj       (rel_obj),
        .result        (result),
        .empty_slabs   (empty_slabs),
        .partial_slabs (partial_slabs),
        .full_slabs    (full_slabs)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_item_reg <= s_data;
        end
        if (advance) begin
            out_item_reg <= result;
        end
    end

    // Every slab is in exactly one of the empty, partial and full classes.
    a_masks_partition: assert property (@(posedge aclk) disable iff (!aresetn)
        ((empty_slabs | partial_slabs | full_slabs) == '1)
        && ((empty_slabs & partial_slabs) == '0)
        && ((empty_slabs & full_slabs) == '0)
        && ((partial_slabs & full_slabs) == '0))
        else $error("slab class masks overlap or leave a slab out");

    // Only a successful allocate returns a nonzero address.
    a_addr_zero_on_fail: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.status != slaballoc_pkg::STATUS_OK) |-> m_data.object_address == '0)
        else $error("object address not zero on a failed item");

    // While a result is stalled, no item may touch the slab state.
    a_stall_freezes_state: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> $stable(full_slabs) && $stable(empty_slabs))
        else $error("slab state changed while the result was stalled");

    // Ready only drops when an item is held and cannot move on.
    a_ready_backpressure: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> in_valid_reg && out_valid_reg && !m_ready)
        else $error("input stalled without a full pipeline");

endmodule
